[sv/qrm_pkg.sv]
// qrm_pkg: widths, lane map and record types for the quaternion to rotation
// matrix pipeline. No dependencies; imported by quaternion_to_rotation_matrix.
`timescale 1ns / 1ps

package qrm_pkg;

  localparam int unsigned CB       = 16;           // component width, Q1.(CB-2)
  localparam int unsigned MAG_W    = CB;           // magnitude of one component
  localparam int unsigned PROD_W   = 2 * CB - 1;   // magnitude of one product
  localparam int unsigned SUM_W    = 2 * CB + 1;   // norm sum, numerators, remainder
  localparam int unsigned OUT_FRAC = 14;
  localparam int unsigned OUT_W    = 16;
  localparam int unsigned NLANE    = 9;
  localparam int unsigned NSTEP    = OUT_FRAC + 2; // quotient bits after the first
  localparam int unsigned QUO_W    = NSTEP + 1;
  localparam int unsigned LATENCY  = NSTEP + 6;

  localparam logic [OUT_W-1:0] OUT_MAX = OUT_W'(1 << OUT_FRAC);

  // lanes 0, 4 and 8 are the diagonal entries
  localparam logic [NLANE-1:0] DIAG_LANES = 9'b100010001;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } comp_t;

  typedef struct packed {
    logic              neg;
    logic [PROD_W-1:0] mag;
  } prod_t;

  function automatic comp_t to_comp(input logic [CB-1:0] v);
    comp_t c;
    c.neg = v[CB-1];
    c.mag = v[CB-1] ? MAG_W'(~v + 1'b1) : MAG_W'(v);
    return c;
  endfunction

  function automatic logic [PROD_W-1:0] mag_mul(input logic [MAG_W-1:0] a,
                                                input logic [MAG_W-1:0] b);
    logic [2*MAG_W-1:0] p;
    p = (2 * MAG_W)'(a) * (2 * MAG_W)'(b);
    return p[PROD_W-1:0];
  endfunction

  function automatic prod_t cross_mul(input comp_t a, input comp_t b);
    prod_t p;
    p.neg = a.neg ^ b.neg;
    p.mag = mag_mul(a.mag, b.mag);
    return p;
  endfunction

  // two's complement form of a sign and magnitude product
  function automatic logic [SUM_W-1:0] to_twos(input prod_t p);
    logic [SUM_W-1:0] v;
    v = SUM_W'(p.mag);
    return p.neg ? (~v + 1'b1) : v;
  endfunction

endpackage

[sv/quaternion_to_rotation_matrix.sv]
// quaternion_to_rotation_matrix: quaternion in, normalized 3x3 rotation matrix out.
// Depends on qrm_pkg; single module, restoring division in nine parallel lanes.
//
// Usage:
//   Drive in_quat_w/x/y/z (signed Q1.14) and raise start; a beat is taken at
//   every rising edge with start high and busy low. busy never rises, so one
//   quaternion can enter every cycle, back to back.
//   The result beat (out_r00..out_r22 in Q1.14 and out_zero_norm) shows on the
//   out_ ports for exactly one cycle with out_valid high. Results leave in input
//   order, one per cycle at full rate.
//   The divider has 17 register stages, one quotient bit per stage, behind
//   four stages of absolute value, products, sums and numerator magnitudes,
//   plus the output register.
//   Entries are rounded to nearest, ties away from zero, and clamped to +-1.0.
//   An all-zero quaternion gives out_zero_norm high and all entries zero.
//   Reset (rst_n low, synchronous) drops every beat in flight; out_valid stays
//   low until new beats come through. The receiver cannot stall the output.
`timescale 1ns / 1ps

module quaternion_to_rotation_matrix (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [qrm_pkg::CB-1:0]    in_quat_w,
  input  logic signed [qrm_pkg::CB-1:0]    in_quat_x,
  input  logic signed [qrm_pkg::CB-1:0]    in_quat_y,
  input  logic signed [qrm_pkg::CB-1:0]    in_quat_z,
  output logic                             out_valid,
  output logic signed [qrm_pkg::OUT_W-1:0] out_r00,
  output logic signed [qrm_pkg::OUT_W-1:0] out_r01,
  output logic signed [qrm_pkg::OUT_W-1:0] out_r02,
  output logic signed [qrm_pkg::OUT_W-1:0] out_r10,
  output logic signed [qrm_pkg::OUT_W-1:0] out_r11,
  output logic signed [qrm_pkg::OUT_W-1:0] out_r12,
  output logic signed [qrm_pkg::OUT_W-1:0] out_r20,
  output logic signed [qrm_pkg::OUT_W-1:0] out_r21,
  output logic signed [qrm_pkg::OUT_W-1:0] out_r22,
  output logic                             out_zero_norm
);

  import qrm_pkg::*;

  // stage 0: component magnitudes
  logic  p0_vld_r, p0_vld_nxt;
  comp_t qw_r, qx_r, qy_r, qz_r;
  comp_t qw_nxt, qx_nxt, qy_nxt, qz_nxt;

  // stage 1: squares and cross products
  logic              p1_vld_r;
  logic [PROD_W-1:0] ww_r, xx_r, yy_r, zz_r;
  logic [PROD_W-1:0] ww_nxt, xx_nxt, yy_nxt, zz_nxt;
  prod_t             xy_r, zw_r, xz_r, yw_r, yz_r, xw_r;
  prod_t             xy_nxt, zw_nxt, xz_nxt, yw_nxt, yz_nxt, xw_nxt;

  // stage 2: norm sum and signed numerators
  logic             p2_vld_r;
  logic [SUM_W-1:0] nrm_r, nrm_nxt;
  logic [SUM_W-1:0] num_r   [NLANE];
  logic [SUM_W-1:0] num_nxt [NLANE];

  // stage 3: numerator sign and magnitude
  logic             p3_vld_r;
  logic [SUM_W-1:0] den3_r, den3_nxt;
  logic             zero3_r, zero3_nxt;
  logic [NLANE-1:0] neg3_r, neg3_nxt;
  logic [SUM_W-1:0] mag3_r   [NLANE];
  logic [SUM_W-1:0] mag3_nxt [NLANE];

  // divider stages, index 0 holds the leading quotient bit
  logic             dv_r     [NSTEP+1];
  logic [SUM_W-1:0] den_r    [NSTEP+1];
  logic [SUM_W-1:0] den_nxt  [NSTEP+1];
  logic             zero_r   [NSTEP+1];
  logic             zero_nxt [NSTEP+1];
  logic [NLANE-1:0] neg_r    [NSTEP+1];
  logic [NLANE-1:0] neg_nxt  [NSTEP+1];
  logic [SUM_W-1:0] rem_r    [NSTEP+1][NLANE];
  logic [SUM_W-1:0] rem_nxt  [NSTEP+1][NLANE];
  logic [QUO_W-1:0] quo_r    [NSTEP+1][NLANE];
  logic [QUO_W-1:0] quo_nxt  [NSTEP+1][NLANE];
  logic [SUM_W:0]   dbl      [NSTEP][NLANE];
  logic [SUM_W+1:0] dif      [NSTEP][NLANE];
  logic [SUM_W+1:0] dif0     [NLANE];

  // output stage
  logic             out_valid_r;
  logic             zero_norm_r, zero_norm_nxt;
  logic [OUT_W-1:0] res_r   [NLANE];
  logic [OUT_W-1:0] res_nxt [NLANE];
  logic [QUO_W-1:0] qsel    [NLANE];
  logic [QUO_W:0]   rnd     [NLANE];
  logic [OUT_W-1:0] sat     [NLANE];

  assign busy       = 1'b0;
  assign p0_vld_nxt = start && !busy;

  always_comb begin
    qw_nxt = to_comp(in_quat_w);
    qx_nxt = to_comp(in_quat_x);
    qy_nxt = to_comp(in_quat_y);
    qz_nxt = to_comp(in_quat_z);
  end

  always_comb begin
    ww_nxt = mag_mul(qw_r.mag, qw_r.mag);
    xx_nxt = mag_mul(qx_r.mag, qx_r.mag);
    yy_nxt = mag_mul(qy_r.mag, qy_r.mag);
    zz_nxt = mag_mul(qz_r.mag, qz_r.mag);
    xy_nxt = cross_mul(qx_r, qy_r);
    zw_nxt = cross_mul(qz_r, qw_r);
    xz_nxt = cross_mul(qx_r, qz_r);
    yw_nxt = cross_mul(qy_r, qw_r);
    yz_nxt = cross_mul(qy_r, qz_r);
    xw_nxt = cross_mul(qx_r, qw_r);
  end

  always_comb begin
    nrm_nxt    = SUM_W'(ww_r) + SUM_W'(xx_r) + SUM_W'(yy_r) + SUM_W'(zz_r);
    num_nxt[0] = (SUM_W'(ww_r) + SUM_W'(xx_r)) - (SUM_W'(yy_r) + SUM_W'(zz_r));
    num_nxt[4] = (SUM_W'(ww_r) + SUM_W'(yy_r)) - (SUM_W'(xx_r) + SUM_W'(zz_r));
    num_nxt[8] = (SUM_W'(ww_r) + SUM_W'(zz_r)) - (SUM_W'(xx_r) + SUM_W'(yy_r));
    num_nxt[1] = to_twos(xy_r) - to_twos(zw_r);
    num_nxt[3] = to_twos(xy_r) + to_twos(zw_r);
    num_nxt[2] = to_twos(xz_r) + to_twos(yw_r);
    num_nxt[6] = to_twos(xz_r) - to_twos(yw_r);
    num_nxt[5] = to_twos(yz_r) - to_twos(xw_r);
    num_nxt[7] = to_twos(yz_r) + to_twos(xw_r);
  end

  always_comb begin
    den3_nxt  = nrm_r;
    zero3_nxt = (nrm_r == '0);
    for (int l = 0; l < NLANE; l++) begin
      neg3_nxt[l] = num_r[l][SUM_W-1];
      mag3_nxt[l] = num_r[l][SUM_W-1] ? (~num_r[l] + 1'b1) : num_r[l];
    end
  end

  // leading quotient bit, then one restoring step per stage
  always_comb begin
    den_nxt[0]  = den3_r;
    zero_nxt[0] = zero3_r;
    neg_nxt[0]  = neg3_r;
    for (int l = 0; l < NLANE; l++) begin
      dif0[l]       = {2'b00, mag3_r[l]} - {2'b00, den3_r};
      rem_nxt[0][l] = dif0[l][SUM_W+1] ? mag3_r[l] : dif0[l][SUM_W-1:0];
      quo_nxt[0][l] = QUO_W'(!dif0[l][SUM_W+1]);
    end
    for (int k = 0; k < NSTEP; k++) begin
      den_nxt[k+1]  = den_r[k];
      zero_nxt[k+1] = zero_r[k];
      neg_nxt[k+1]  = neg_r[k];
      for (int l = 0; l < NLANE; l++) begin
        dbl[k][l]       = {rem_r[k][l], 1'b0};
        dif[k][l]       = {1'b0, dbl[k][l]} - {2'b00, den_r[k]};
        rem_nxt[k+1][l] = dif[k][l][SUM_W+1] ? dbl[k][l][SUM_W-1:0] : dif[k][l][SUM_W-1:0];
        quo_nxt[k+1][l] = {quo_r[k][l][QUO_W-2:0], !dif[k][l][SUM_W+1]};
      end
    end
  end

  // round half up on the magnitude, clamp, apply sign
  always_comb begin
    zero_norm_nxt = zero_r[NSTEP];
    for (int l = 0; l < NLANE; l++) begin
      qsel[l] = DIAG_LANES[l] ? {1'b0, quo_r[NSTEP][l][QUO_W-1:1]} : quo_r[NSTEP][l];
      rnd[l]  = (QUO_W + 1)'(qsel[l]) + 1'b1;
      sat[l]  = (rnd[l][QUO_W:1] > QUO_W'(OUT_MAX)) ? OUT_MAX : rnd[l][OUT_W:1];
      if (zero_r[NSTEP]) begin
        res_nxt[l] = '0;
      end else if (neg_r[NSTEP][l]) begin
        res_nxt[l] = ~sat[l] + 1'b1;
      end else begin
        res_nxt[l] = sat[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_vld_r    <= 1'b0;
      p1_vld_r    <= 1'b0;
      p2_vld_r    <= 1'b0;
      p3_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k <= NSTEP; k++) begin
        dv_r[k] <= 1'b0;
      end
    end else begin
      p0_vld_r    <= p0_vld_nxt;
      p1_vld_r    <= p0_vld_r;
      p2_vld_r    <= p1_vld_r;
      p3_vld_r    <= p2_vld_r;
      dv_r[0]     <= p3_vld_r;
      for (int k = 0; k < NSTEP; k++) begin
        dv_r[k+1] <= dv_r[k];
      end
      out_valid_r <= dv_r[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    qw_r    <= qw_nxt;
    qx_r    <= qx_nxt;
    qy_r    <= qy_nxt;
    qz_r    <= qz_nxt;
    ww_r    <= ww_nxt;
    xx_r    <= xx_nxt;
    yy_r    <= yy_nxt;
    zz_r    <= zz_nxt;
    xy_r    <= xy_nxt;
    zw_r    <= zw_nxt;
    xz_r    <= xz_nxt;
    yw_r    <= yw_nxt;
    yz_r    <= yz_nxt;
    xw_r    <= xw_nxt;
    nrm_r   <= nrm_nxt;
    den3_r  <= den3_nxt;
    zero3_r <= zero3_nxt;
    neg3_r  <= neg3_nxt;
    for (int l = 0; l < NLANE; l++) begin
      num_r[l]  <= num_nxt[l];
      mag3_r[l] <= mag3_nxt[l];
      res_r[l]  <= res_nxt[l];
    end
    for (int k = 0; k <= NSTEP; k++) begin
      den_r[k]  <= den_nxt[k];
      zero_r[k] <= zero_nxt[k];
      neg_r[k]  <= neg_nxt[k];
      for (int l = 0; l < NLANE; l++) begin
        rem_r[k][l] <= rem_nxt[k][l];
        quo_r[k][l] <= quo_nxt[k][l];
      end
    end
    zero_norm_r <= zero_norm_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_zero_norm = zero_norm_r;
  assign out_r00       = res_r[0];
  assign out_r01       = res_r[1];
  assign out_r02       = res_r[2];
  assign out_r10       = res_r[3];
  assign out_r11       = res_r[4];
  assign out_r12       = res_r[5];
  assign out_r20       = res_r[6];
  assign out_r21       = res_r[7];
  assign out_r22       = res_r[8];

`ifndef SYNTHESIS
  a_beat_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(LATENCY) out_valid)
    else $error("accepted beat did not come out after the pipeline latency");

  a_beat_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result strobe without a matching accepted beat");

  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_zero_norm == $past(in_quat_w == '0 && in_quat_x == '0 &&
                                          in_quat_y == '0 && in_quat_z == '0, LATENCY)))
    else $error("zero norm flag does not match the quaternion it belongs to");

  a_zero_entries: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_norm) |->
      (out_r00 == '0 && out_r01 == '0 && out_r02 == '0 &&
       out_r10 == '0 && out_r11 == '0 && out_r12 == '0 &&
       out_r20 == '0 && out_r21 == '0 && out_r22 == '0))
    else $error("zero quaternion gave nonzero matrix entries");
`endif

endmodule
